// ===== hw/rtl/nta_pkg.sv =====
package nta_pkg;

  localparam int unsigned ENTRIES_DEF = 16;

  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned STR_W    = 8;
  localparam int unsigned LIFE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  // configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [LIFE_W-1:0] TTL_RESET = 8'd30;

  typedef enum logic {
    REG_TTL_RELOAD = 1'b0,
    REG_NONE       = 1'b1
  } reg_idx_e;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_REFRESHED = 2'd0,
    STATUS_INSERTED  = 2'd1,
    STATUS_DROPPED   = 2'd2,
    STATUS_TICK      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_DRAIN = 2'd2,
    ST_WRITE = 2'd3
  } state_e;

endpackage

// ===== hw/rtl/nta_req_if.sv =====
interface nta_req_if;
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic [nta_pkg::ADDR_W-1:0]     peer_address;
  logic signed [nta_pkg::STR_W-1:0] signal_strength;

  modport source (output valid, output op, output peer_address, output signal_strength,
                  input ready);
  modport sink (input valid, input op, input peer_address, input signal_strength,
                output ready);
endinterface

// ===== hw/rtl/nta_rsp_if.sv =====
interface nta_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [nta_pkg::STATUS_W-1:0]    status;
  logic [nta_pkg::SLOT_W-1:0]      slot_index;
  logic [nta_pkg::COUNT_W-1:0]     expired_count;

  modport source (output valid, output status, output slot_index, output expired_count,
                  input ready);
  modport sink (input valid, input status, input slot_index, input expired_count,
                output ready);
endinterface

// ===== hw/rtl/nta_ram.sv =====
module nta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/nta_apb_regs.sv =====
module nta_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nta_pkg::PADDR_W-1:0]  paddr,
  input  logic [nta_pkg::PDATA_W-1:0]  pwdata,
  output logic [nta_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [nta_pkg::LIFE_W-1:0]   ttl_reload_o
);

  logic [nta_pkg::LIFE_W-1:0] ttl_q, ttl_d;
  logic                       wr_ttl;

  // word-aligned decode, byte offset bits ignored
  assign wr_ttl = psel && penable && pwrite
                  && (paddr[2] == nta_pkg::REG_TTL_RELOAD);
  assign pready = 1'b1;

  always_comb begin
    ttl_d = ttl_q;
    if (wr_ttl) begin
      ttl_d = pwdata[nta_pkg::LIFE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == nta_pkg::REG_TTL_RELOAD) begin
      prdata = {{(nta_pkg::PDATA_W-nta_pkg::LIFE_W){1'b0}}, ttl_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= nta_pkg::TTL_RESET;
    end else begin
      ttl_q <= ttl_d;
    end
  end

  assign ttl_reload_o = ttl_q;

endmodule

// ===== hw/rtl/nta_scan.sv =====
module nta_scan #(
  parameter int unsigned ENTRIES = nta_pkg::ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [nta_pkg::LIFE_W-1:0] ttl_reload_i,
  nta_req_if.sink                    req_i,
  nta_rsp_if.source                  rsp_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRIES - 1);

  nta_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        chk_q;
  logic [IDX_W-1:0]            chk_idx_q;
  logic                        found_q, found_d;
  logic [IDX_W-1:0]            hit_q, hit_d;
  logic                        free_ok_q, free_ok_d;
  logic [IDX_W-1:0]            free_q, free_d;
  logic [nta_pkg::COUNT_W-1:0] exp_q, exp_d;
  logic [ENTRIES-1:0]          used_q, used_d;

  nta_pkg::op_e                op_q;
  logic [nta_pkg::ADDR_W-1:0]  addr_q;
  logic [nta_pkg::STR_W-1:0]   str_q;

  logic                        out_valid_q, out_valid_d;
  logic [nta_pkg::STATUS_W-1:0] out_status_q;
  logic [nta_pkg::SLOT_W-1:0]  out_slot_q;
  logic [nta_pkg::COUNT_W-1:0] out_exp_q;

  logic                        accept, out_free, out_load;
  logic [IDX_W-1:0]            rd_idx, sel_idx;
  logic [nta_pkg::ADDR_W-1:0]  addr_rd;
  logic [nta_pkg::LIFE_W-1:0]  life_rd;
  logic                        chk_used, match, free_hit, expire, age;
  logic                        wr_go;
  logic                        life_we;
  logic [IDX_W-1:0]            life_waddr;
  logic [nta_pkg::LIFE_W-1:0]  life_wdata;
  nta_pkg::status_e            res_status;
  logic [IDX_W+nta_pkg::SLOT_W-1:0] slot_ext;
  logic [nta_pkg::SLOT_W-1:0]  res_slot;

  assign out_free = !out_valid_q || rsp_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nta_pkg::ST_IDLE:  if (req_i.valid) state_d = nta_pkg::ST_SCAN;
      nta_pkg::ST_SCAN:  if (cnt_q == CNT_LAST) state_d = nta_pkg::ST_DRAIN;
      nta_pkg::ST_DRAIN: state_d = nta_pkg::ST_WRITE;
      nta_pkg::ST_WRITE: if (out_free) state_d = nta_pkg::ST_IDLE;
      default:           state_d = nta_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs and the shared compare / decrement unit
  always_comb begin
    req_i.ready = (state_q == nta_pkg::ST_IDLE);
    accept      = req_i.valid && req_i.ready;
    rd_idx      = cnt_q[IDX_W-1:0];

    chk_used = used_q[chk_idx_q];
    match    = chk_q && (op_q == nta_pkg::OP_ADD) && chk_used && !found_q
               && (addr_rd == addr_q);
    free_hit = chk_q && (op_q == nta_pkg::OP_ADD) && !chk_used && !free_ok_q;
    expire   = chk_q && (op_q == nta_pkg::OP_TICK) && chk_used
               && (life_rd <= nta_pkg::LIFE_W'(1));
    age      = chk_q && (op_q == nta_pkg::OP_TICK) && chk_used && !expire;

    sel_idx = found_q ? hit_q : free_q;
    wr_go   = (state_q == nta_pkg::ST_WRITE) && (op_q == nta_pkg::OP_ADD)
              && (found_q || free_ok_q);

    life_we    = age || wr_go;
    life_waddr = age ? chk_idx_q : sel_idx;
    life_wdata = age ? (life_rd - nta_pkg::LIFE_W'(1)) : ttl_reload_i;

    if (op_q == nta_pkg::OP_TICK) begin
      res_status = nta_pkg::STATUS_TICK;
    end else if (found_q) begin
      res_status = nta_pkg::STATUS_REFRESHED;
    end else if (free_ok_q) begin
      res_status = nta_pkg::STATUS_INSERTED;
    end else begin
      res_status = nta_pkg::STATUS_DROPPED;
    end
    // slot number carried as its low bits
    slot_ext = {{nta_pkg::SLOT_W{1'b0}}, sel_idx};
    res_slot = ((op_q == nta_pkg::OP_ADD) && (found_q || free_ok_q))
               ? slot_ext[nta_pkg::SLOT_W-1:0] : '0;

    out_load = (state_q == nta_pkg::ST_WRITE) && out_free;

    cnt_d     = cnt_q;
    found_d   = found_q;
    hit_d     = hit_q;
    free_ok_d = free_ok_q;
    free_d    = free_q;
    exp_d     = exp_q;
    used_d    = used_q;

    if (accept) begin
      cnt_d     = '0;
      found_d   = 1'b0;
      free_ok_d = 1'b0;
      exp_d     = '0;
    end
    if (state_q == nta_pkg::ST_SCAN) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
    if (match) begin
      found_d = 1'b1;
      hit_d   = chk_idx_q;
    end
    if (free_hit) begin
      free_ok_d = 1'b1;
      free_d    = chk_idx_q;
    end
    if (expire) begin
      used_d[chk_idx_q] = 1'b0;
      if (exp_q != nta_pkg::COUNT_MAX) begin
        exp_d = exp_q + nta_pkg::COUNT_W'(1);
      end
    end
    if (wr_go && !found_q) begin
      used_d[free_q] = 1'b1;
    end

    out_valid_d = out_valid_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nta_pkg::ST_IDLE;
      cnt_q       <= '0;
      chk_q       <= 1'b0;
      found_q     <= 1'b0;
      free_ok_q   <= 1'b0;
      exp_q       <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      chk_q       <= (state_q == nta_pkg::ST_SCAN);
      found_q     <= found_d;
      free_ok_q   <= free_ok_d;
      exp_q       <= exp_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= rd_idx;
    hit_q     <= hit_d;
    free_q    <= free_d;
    if (accept) begin
      op_q   <= nta_pkg::op_e'(req_i.op);
      addr_q <= req_i.peer_address;
      str_q  <= req_i.signal_strength;
    end
    if (out_load) begin
      out_status_q <= res_status;
      out_slot_q   <= res_slot;
      out_exp_q    <= exp_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.slot_index    = out_slot_q;
  assign rsp_o.expired_count = out_exp_q;

  nta_ram #(.WIDTH(nta_pkg::ADDR_W), .DEPTH(ENTRIES)) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (wr_go && !found_q),
    .waddr_i (free_q),
    .wdata_i (addr_q),
    .raddr_i (rd_idx),
    .rdata_o (addr_rd)
  );

  // strength is kept per entry but never read back on the item path
  nta_ram #(.WIDTH(nta_pkg::STR_W), .DEPTH(ENTRIES)) u_str_ram (
    .clk_i   (clk_i),
    .we_i    (wr_go),
    .waddr_i (sel_idx),
    .wdata_i (str_q),
    .raddr_i (rd_idx),
    .rdata_o ()
  );

  nta_ram #(.WIDTH(nta_pkg::LIFE_W), .DEPTH(ENTRIES)) u_life_ram (
    .clk_i   (clk_i),
    .we_i    (life_we),
    .waddr_i (life_waddr),
    .wdata_i (life_wdata),
    .raddr_i (rd_idx),
    .rdata_o (life_rd)
  );

endmodule

// ===== hw/rtl/neighbor_table_with_aging.sv =====
// one item at a time: the table is scanned, one slot read per cycle through the
// shared compare / decrement unit, then drain and write; write waits for a free
// result register, and no new item is taken until the result is loaded
// reset: all slots free, ttl_reload 30, no result pending; slot contents behind a
// free flag are never looked at, so the tables themselves need no clearing
module neighbor_table_with_aging #(
  parameter int unsigned ENTRIES = nta_pkg::ENTRIES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nta_pkg::PADDR_W-1:0] paddr,
  input  logic [nta_pkg::PDATA_W-1:0] pwdata,
  output logic [nta_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  nta_req_if.sink                     req_i,
  nta_rsp_if.source                   rsp_o
);

  logic [nta_pkg::LIFE_W-1:0] ttl_reload;

  nta_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .ttl_reload_o (ttl_reload)
  );

  nta_scan #(.ENTRIES(ENTRIES)) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ttl_reload_i (ttl_reload),
    .req_i        (req_i),
    .rsp_o        (rsp_o)
  );

endmodule

// ===== sim/tb_neighbor_table_with_aging.sv =====
module tb_neighbor_table_with_aging;
  timeunit 1ns;
  timeprecision 1ps;

  import nta_pkg::*;

  localparam int unsigned ENTRIES    = ENTRIES_DEF;
  localparam int unsigned QUIET_MAX  = 4000;
  localparam int unsigned IDLE_PCT   = 31;

  typedef struct packed {
    status_e            status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] expired;
  } outcome_t;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [STR_W-1:0]  strength;
  } peer_item_t;

  logic clk = 1'b0;
  logic rst_n;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  nta_req_if req_if ();
  nta_rsp_if rsp_if ();

  neighbor_table_with_aging #(
    .ENTRIES (ENTRIES)
  ) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_if),
    .rsp_o   (rsp_if)
  );

  always #6 clk = ~clk;

  // shadow of the peer table
  logic [ADDR_W-1:0] peer_addr_tbl [ENTRIES];
  logic [STR_W-1:0]  strength_tbl  [ENTRIES];
  logic [LIFE_W-1:0] life_tbl      [ENTRIES];
  bit                used_tbl      [ENTRIES];
  logic [LIFE_W-1:0] ttl_now = TTL_RESET;

  peer_item_t pending_items [$];
  outcome_t   due_outcomes  [$];
  int unsigned failures = 0;
  bit calm = 1'b0;

  function automatic void forget_slot(int unsigned s);
    peer_addr_tbl[s] = '0;
    strength_tbl[s]  = '0;
    life_tbl[s]      = '0;
    used_tbl[s]      = 1'b0;
  endfunction

  function automatic outcome_t learn_or_age(op_e op, logic [ADDR_W-1:0] addr,
                                            logic [STR_W-1:0] strength);
    outcome_t res;
    int hit;
    int free_slot;
    res.status  = STATUS_TICK;
    res.slot    = '0;
    res.expired = '0;
    if (op == OP_TICK) begin
      for (int s = 0; s < ENTRIES; s++) begin
        if (used_tbl[s]) begin
          // life of 0 or 1 both expire, so the count never wraps
          if (life_tbl[s] <= 1) begin
            forget_slot(s);
            if (res.expired != COUNT_MAX) res.expired = res.expired + 1'b1;
          end else begin
            life_tbl[s] = life_tbl[s] - 1'b1;
          end
        end
      end
    end else begin
      hit = -1;
      free_slot = -1;
      for (int s = 0; s < ENTRIES; s++) begin
        if (used_tbl[s]) begin
          if (hit < 0 && peer_addr_tbl[s] == addr) hit = s;
        end else if (free_slot < 0) begin
          free_slot = s;
        end
      end
      if (hit >= 0) begin
        life_tbl[hit]     = ttl_now;
        strength_tbl[hit] = strength;
        res.status        = STATUS_REFRESHED;
        res.slot          = SLOT_W'(hit);
      end else if (free_slot >= 0) begin
        peer_addr_tbl[free_slot] = addr;
        strength_tbl[free_slot]  = strength;
        life_tbl[free_slot]      = ttl_now;
        used_tbl[free_slot]      = 1'b1;
        res.status               = STATUS_INSERTED;
        res.slot                 = SLOT_W'(free_slot);
      end else begin
        res.status = STATUS_DROPPED;
      end
    end
    return res;
  endfunction

  // request driver
  always @(posedge clk) begin : drive_req
    peer_item_t nxt;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        due_outcomes.push_back(learn_or_age(op_e'(req_if.op), req_if.peer_address,
                                            req_if.signal_strength));
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = pending_items.pop_front();
          req_if.valid           <= 1'b1;
          req_if.op              <= nxt.op;
          req_if.peer_address    <= nxt.addr;
          req_if.signal_strength <= nxt.strength;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : watch_rsp
    outcome_t want;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (due_outcomes.size() == 0) begin
          failures++;
          $error("result item with nothing expected: status %0d slot %0d expired %0d",
                 rsp_if.status, rsp_if.slot_index, rsp_if.expired_count);
        end else begin
          want = due_outcomes.pop_front();
          if (rsp_if.status !== want.status) begin
            failures++;
            $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          end
          if (rsp_if.slot_index !== want.slot) begin
            failures++;
            $error("slot_index: expected %0d, got %0d", want.slot, rsp_if.slot_index);
          end
          if (rsp_if.expired_count !== want.expired) begin
            failures++;
            $error("expired_count: expected %0d, got %0d", want.expired,
                   rsp_if.expired_count);
          end
        end
      end
      rsp_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if (!rst_n) begin
      quiet = 0;
    end else begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_MAX) begin
        $display("** neighbor_table_with_aging: FAILED **");
        $finish;
      end
    end
  end

  function automatic logic [ADDR_W-1:0] any_address();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic void queue_item(op_e op, logic [ADDR_W-1:0] addr,
                                     logic [STR_W-1:0] strength);
    peer_item_t it;
    it.op       = op;
    it.addr     = addr;
    it.strength = strength;
    pending_items.push_back(it);
  endfunction

  function automatic void queue_tick();
    queue_item(OP_TICK, any_address(), STR_W'($urandom));
  endfunction

  task automatic apb_write(input reg_idx_e idx, input logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << 2;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_TTL_RELOAD) ttl_now = data[LIFE_W-1:0];
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || req_if.valid || due_outcomes.size() != 0);
  endtask

  // random churn: mostly adds from a small address pool so the table fills,
  // ages out and refills, with stray addresses and ticks mixed in
  task automatic churn(input logic [LIFE_W-1:0] ttl, input int unsigned n_items,
                       input int unsigned tick_pct, input int unsigned pool_n,
                       input bit quiet_run);
    logic [ADDR_W-1:0] pool [$];
    int unsigned roll;
    apb_write(REG_TTL_RELOAD, PDATA_W'(ttl));
    calm = quiet_run;
    pool.push_back('0);
    pool.push_back('1);
    while (pool.size() < pool_n) pool.push_back(any_address());
    for (int unsigned i = 0; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < tick_pct) begin
        queue_tick();
      end else if (roll < tick_pct + 5) begin
        queue_item(OP_ADD, any_address(), STR_W'($urandom));
      end else begin
        queue_item(OP_ADD, pool[$urandom_range(0, pool.size() - 1)], STR_W'($urandom));
      end
    end
    wait_drained();
    calm = 1'b0;
  endtask

  initial begin
    rst_n                  = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    req_if.valid           = 1'b0;
    req_if.op              = OP_ADD;
    req_if.peer_address    = '0;
    req_if.signal_strength = '0;
    rsp_if.ready           = 1'b0;
    for (int s = 0; s < ENTRIES; s++) forget_slot(s);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero address must not match free slots, then refresh it
    queue_item(OP_ADD, '0, 8'h80);
    queue_item(OP_ADD, '0, 8'h7f);
    queue_item(OP_ADD, '1, 8'h00);
    queue_item(OP_ADD, 48'h5555_5555_5555, 8'hff);
    queue_tick();
    wait_drained();

    // zero reload: fresh and refreshed entries expire on the next tick
    apb_write(REG_TTL_RELOAD, '0);
    queue_item(OP_ADD, 48'haaaa_aaaa_aaaa, 8'h01);
    queue_item(OP_ADD, 48'h5555_5555_5555, 8'h40);
    queue_tick();
    wait_drained();

    // a write to an unmapped register has no effect
    apb_write(REG_TTL_RELOAD, 32'd255);
    apb_write(REG_NONE, 32'd7);
    for (int i = 0; i < 14; i++) begin
      queue_item(OP_ADD, 48'h0123_4567_0000 | ADDR_W'(i), STR_W'(i * 17));
    end
    queue_item(OP_ADD, 48'hdead_beef_0001, 8'hc0);
    queue_item(OP_ADD, '1, 8'h55);
    wait_drained();

    churn(8'd1, 200, 20, 20, 1'b0);
    churn(8'd255, 200, 15, 24, 1'b1);
    churn(8'd0, 180, 25, 18, 1'b0);
    churn(8'd2, 240, 30, 22, 1'b0);
    churn(8'd3, 240, 25, 30, 1'b0);
    churn(LIFE_W'($urandom_range(4, 12)), 220, 20, 20, 1'b0);

    repeat (ENTRIES + 12) @(posedge clk);
    if (failures == 0 && due_outcomes.size() == 0) begin
      $display("** neighbor_table_with_aging: PASSED **");
    end else begin
      $display("** neighbor_table_with_aging: FAILED **");
    end
    $finish;
  end

endmodule
